// ===== design/icce_pkg.sv =====
// Shared types and constants of the clamped-edge image convolution block.
package icce_pkg;

    localparam int unsigned PIX_W  = 32;
    localparam int unsigned TAP_W  = 8;
    localparam int unsigned PROD_W = 17;
    localparam int unsigned SUM_W  = 21;
    localparam int unsigned REM_W  = 24;
    localparam int unsigned DIV_W  = 16;

    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_DIVISOR  = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_CHANNELS = 3'd3;
    localparam logic [2:0] REG_TAPS_LO  = 3'd4;
    localparam logic [2:0] REG_TAPS_MID = 3'd5;
    localparam logic [2:0] REG_TAPS_HI  = 3'd6;
    localparam logic [2:0] REG_TAP_LAST = 3'd7;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [PIX_W-1:0] word;
        logic [TAP_W-1:0] tap;
    } icce_link_t;

    typedef struct packed {
        logic       done;
        logic [7:0] result;
    } icce_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WAIT
    } icce_state_t;

endpackage

// ===== design/icce_cell.sv =====
// One channel cell: tap multiply, accumulate, divide and clamp, forwarding samples down the chain.
module icce_cell #(
    parameter int unsigned LANE = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  icce_pkg::icce_link_t              link_in,
    input  logic [icce_pkg::DIV_W-1:0]        divisor,
    output icce_pkg::icce_link_t              link_out,
    output icce_pkg::icce_stat_t              stat_out
);

    icce_pkg::icce_link_t                  link_reg;
    logic signed [icce_pkg::PROD_W-1:0]    prod_reg;
    logic                                  pv_reg;
    logic                                  pf_reg;
    logic                                  pl_reg;
    logic signed [icce_pkg::SUM_W-1:0]     acc_reg;
    logic                                  fin_reg;
    logic [icce_pkg::REM_W-1:0]            rem_reg;
    logic [icce_pkg::REM_W-1:0]            dsh_reg;
    logic [7:0]                            q_reg;
    logic [2:0]                            cnt_reg;
    logic                                  busy_reg;
    logic                                  done_reg;
    logic [7:0]                            res_reg;

    logic [7:0]                            sample;
    logic [icce_pkg::REM_W-1:0]            acc_mag;
    logic [icce_pkg::REM_W-1:0]            dlim;
    logic                                  fits;
    logic [7:0]                            q_next;

    assign sample   = link_in.word[LANE*8 +: 8];
    assign acc_mag  = icce_pkg::REM_W'(acc_reg[icce_pkg::SUM_W-2:0]);
    assign dlim     = {divisor, 8'd0};
    assign fits     = rem_reg >= dsh_reg;
    assign link_out = link_reg;
    assign stat_out = '{done: done_reg, result: res_reg};

    always_comb
    begin
        q_next = q_reg;
        if (fits)
        begin
            q_next[cnt_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
            pv_reg   <= 1'b0;
            pf_reg   <= 1'b0;
            pl_reg   <= 1'b0;
            fin_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            link_reg <= link_in;
            pv_reg   <= link_in.valid;
            pf_reg   <= link_in.first;
            pl_reg   <= link_in.last;
            fin_reg  <= pv_reg && pl_reg;
            if (link_in.valid && link_in.first)
            begin
                done_reg <= 1'b0;
            end
            if (fin_reg)
            begin
                if (acc_reg <= 0 || acc_mag >= dlim)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg && cnt_reg == 3'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= icce_pkg::PROD_W'($signed({1'b0, sample}) * $signed(link_in.tap));
        if (pv_reg)
        begin
            acc_reg <= pf_reg ? icce_pkg::SUM_W'(prod_reg)
                              : acc_reg + icce_pkg::SUM_W'(prod_reg);
        end
        if (fin_reg)
        begin
            rem_reg <= acc_mag;
            dsh_reg <= icce_pkg::REM_W'({divisor, 7'd0});
            q_reg   <= 8'd0;
            cnt_reg <= 3'd7;
            if (acc_reg <= 0)
            begin
                res_reg <= 8'd0;
            end
            else if (acc_mag >= dlim)
            begin
                res_reg <= 8'hFF;
            end
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= q_next;
            cnt_reg <= cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                res_reg <= q_next;
            end
        end
    end

endmodule

// ===== design/image_convolution_clamped_edges.sv =====
// Top level: line ring, tap sweep sequencer, channel cell chain and output register.
//
// Pixels are written into a ring of MAX_WIDTH*(2*MAX_RADIUS+1) words. A push
// that still fills the initial lag of radius rows plus radius pixels is taken
// without a sweep and gives no word. A push or drain that yields an output runs
// a sweep that reads the centre and then one kernel sample per cycle from the
// single read port of the ring (10 reads for 3x3, 26 for 5x5); the samples and
// taps ripple through one cell per channel, each cell multiplying, accumulating
// and then dividing in 8 restoring steps, or clamping at once to 0 or 255. The
// next item is taken once the word is in the output register.
module image_convolution_clamped_edges #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_RADIUS = 2,
    parameter int unsigned CHANNELS   = 4,
    parameter int unsigned COEF_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  in_byte0,
    input  logic [7:0]  in_byte1,
    input  logic [7:0]  in_byte2,
    input  logic [7:0]  in_byte3,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte0,
    output logic [7:0]  out_byte1,
    output logic [7:0]  out_byte2,
    output logic [7:0]  out_byte3,
    output logic        out_last
);

    localparam int unsigned DEPTH  = MAX_WIDTH * (2 * MAX_RADIUS + 1);
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
    localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMP_W  = WID_W + 1;
    localparam int unsigned CX_W   = COL_W + 3;
    localparam int unsigned SA_W   = ADDR_W + 3;
    localparam int unsigned LAG_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int unsigned TW     = (COEF_BITS < 8) ? COEF_BITS : 8;

    // configuration
    logic [1:0]  radius_reg;
    logic [15:0] divisor_reg;
    logic [10:0] width_reg;
    logic [2:0]  chan_reg;
    logic [63:0] taps_lo_reg;
    logic [63:0] taps_mid_reg;
    logic [63:0] taps_hi_reg;
    logic [7:0]  tap_last_reg;

    // frame state
    icce_pkg::icce_state_t state_reg, state_next;
    logic [LAG_W-1:0]  lag_reg, lag_next;
    logic [COL_W-1:0]  wcol_reg, wcol_next;
    logic [15:0]       wrow_reg, wrow_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [15:0]       fheight_reg, fheight_next;
    logic              closed_reg, closed_next;
    logic [COL_W-1:0]  ecol_reg, ecol_next;
    logic [15:0]       erow_reg, erow_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;

    // sweep
    logic              centre_ph_reg, centre_ph_next;
    logic signed [2:0] dy_reg, dy_next;
    logic signed [2:0] dx_reg, dx_next;
    logic [4:0]        k_reg, k_next;
    logic              rv_reg, rv_next;
    logic              rc_reg, rc_next;
    logic              rf_reg, rf_next;
    logic              rl_reg, rl_next;
    logic [7:0]        tap_reg;
    logic [31:0]       rdata_reg;
    logic [31:0]       centre_reg;

    // output
    logic              out_valid_reg, out_valid_next;
    logic              load_out;
    logic [7:0]        ob_reg [4];
    logic              olast_reg;

    logic [31:0]       mem [DEPTH];
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] raddr;

    logic [1:0]              r_eff;
    logic signed [2:0]       rs;
    logic [WID_W-1:0]        w_eff;
    logic [2:0]              nch_eff;
    logic [15:0]             div_eff;
    logic [LAG_W-1:0]        lag_lim;
    logic [15:0]             last_row;
    logic                    wcol_wrap;
    logic                    ecol_wrap;
    logic                    emit_last;

    logic signed [17:0]      ry_raw;
    logic signed [17:0]      ry;
    logic signed [17:0]      dyp;
    logic signed [CX_W-1:0]  cx_raw;
    logic signed [CX_W-1:0]  cx;
    logic signed [CX_W-1:0]  wmax;
    logic signed [CX_W-1:0]  dxp;
    logic signed [SA_W-1:0]  off;
    logic signed [SA_W-1:0]  asum;
    logic [ADDR_W-1:0]       tap_addr;

    logic [199:0]            taps_all;
    logic [7:0]              tap_byte;
    logic [7:0]              tap_ext;

    icce_pkg::icce_link_t    link [CHANNELS+1];
    icce_pkg::icce_stat_t    stat [CHANNELS];
    logic                    all_done;
    logic [7:0]              res_byte [4];

    // effective register values
    always_comb
    begin
        r_eff = (radius_reg >= 2'd2 && MAX_RADIUS >= 2) ? 2'd2 : 2'd1;
        rs    = $signed({1'b0, r_eff});
        if (width_reg == 11'd0)
        begin
            w_eff = WID_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WID_W'(width_reg);
        end
        if (chan_reg == 3'd0)
        begin
            nch_eff = 3'd1;
        end
        else if (32'(chan_reg) > CHANNELS)
        begin
            nch_eff = 3'(CHANNELS);
        end
        else
        begin
            nch_eff = chan_reg;
        end
        div_eff = (divisor_reg == 16'd0) ? 16'd1 : divisor_reg;
        lag_lim = (r_eff == 2'd2) ? LAG_W'({w_eff, 1'b0}) + LAG_W'(2)
                                  : LAG_W'(w_eff) + LAG_W'(1);
    end

    assign last_row  = fheight_reg - 16'd1;
    assign wcol_wrap = CMP_W'(wcol_reg) + CMP_W'(1) >= CMP_W'(w_eff);
    assign ecol_wrap = CMP_W'(ecol_reg) + CMP_W'(1) >= CMP_W'(w_eff);
    assign emit_last = closed_reg && erow_reg == last_row && ecol_wrap;

    // neighbour address with clamp to edge
    always_comb
    begin
        ry_raw = $signed({2'b00, erow_reg}) + 18'(dy_reg);
        ry     = (ry_raw < 0) ? 18'sd0 : ry_raw;
        if (closed_reg && ry > $signed({2'b00, last_row}))
        begin
            ry = $signed({2'b00, last_row});
        end
        dyp    = ry - $signed({2'b00, erow_reg});
        cx_raw = $signed({3'b000, ecol_reg}) + CX_W'(dx_reg);
        wmax   = $signed(CX_W'(w_eff)) - CX_W'(1);
        cx     = (cx_raw < 0) ? CX_W'(0) : cx_raw;
        if (cx > wmax)
        begin
            cx = wmax;
        end
        dxp  = cx - $signed({3'b000, ecol_reg});
        off  = SA_W'($signed(dyp[3:0])) * SA_W'($signed({1'b0, w_eff})) + SA_W'(dxp);
        asum = $signed({3'b000, rd_addr_reg}) + off;
        if (asum < 0)
        begin
            asum = asum + SA_W'(DEPTH);
        end
        else if (asum >= SA_W'(DEPTH))
        begin
            asum = asum - SA_W'(DEPTH);
        end
        tap_addr = asum[ADDR_W-1:0];
    end

    assign taps_all = {tap_last_reg, taps_hi_reg, taps_mid_reg, taps_lo_reg};
    assign tap_byte = taps_all[k_reg*8 +: 8];
    assign tap_ext  = 8'($signed(tap_byte[TW-1:0]));

    always_comb
    begin
        all_done = 1'b1;
        for (int unsigned i = 0; i < CHANNELS; i++)
        begin
            all_done = all_done & stat[i].done;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        lag_next       = lag_reg;
        wcol_next      = wcol_reg;
        wrow_next      = wrow_reg;
        wr_addr_next   = wr_addr_reg;
        fheight_next   = fheight_reg;
        closed_next    = closed_reg;
        ecol_next      = ecol_reg;
        erow_next      = erow_reg;
        rd_addr_next   = rd_addr_reg;
        centre_ph_next = centre_ph_reg;
        dy_next        = dy_reg;
        dx_next        = dx_reg;
        k_next         = k_reg;
        rv_next        = 1'b0;
        rc_next        = 1'b0;
        rf_next        = 1'b0;
        rl_next        = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        load_out       = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        raddr          = rd_addr_reg;
        in_ready       = 1'b0;

        unique case (state_reg)
            icce_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == icce_pkg::OP_DRAIN)
                    begin
                        if (closed_reg)
                        begin
                            state_next = icce_pkg::ST_SWEEP;
                        end
                    end
                    else if (!closed_reg)
                    begin
                        mem_we       = 1'b1;
                        wr_addr_next = (wr_addr_reg == ADDR_W'(DEPTH - 1))
                                     ? '0 : wr_addr_reg + ADDR_W'(1);
                        if (frame_end)
                        begin
                            fheight_next = wrow_reg + 16'd1;
                            closed_next  = 1'b1;
                        end
                        if (wcol_wrap)
                        begin
                            wcol_next = '0;
                            wrow_next = wrow_reg + 16'd1;
                        end
                        else
                        begin
                            wcol_next = wcol_reg + COL_W'(1);
                        end
                        if (lag_reg >= lag_lim)
                        begin
                            state_next = icce_pkg::ST_SWEEP;
                        end
                        else
                        begin
                            lag_next = lag_reg + LAG_W'(1);
                        end
                    end
                    if (state_next == icce_pkg::ST_SWEEP)
                    begin
                        centre_ph_next = 1'b1;
                        dy_next        = 3'sd0 - rs;
                        dx_next        = 3'sd0 - rs;
                        k_next         = 5'd0;
                    end
                end
            end

            icce_pkg::ST_SWEEP:
            begin
                mem_re  = 1'b1;
                rv_next = 1'b1;
                if (centre_ph_reg)
                begin
                    rc_next        = 1'b1;
                    centre_ph_next = 1'b0;
                end
                else
                begin
                    raddr   = tap_addr;
                    rf_next = k_reg == 5'd0;
                    rl_next = dy_reg == rs && dx_reg == rs;
                    k_next  = k_reg + 5'd1;
                    if (dx_reg == rs)
                    begin
                        dx_next = 3'sd0 - rs;
                        dy_next = dy_reg + 3'sd1;
                        if (dy_reg == rs)
                        begin
                            state_next = icce_pkg::ST_WAIT;
                        end
                    end
                    else
                    begin
                        dx_next = dx_reg + 3'sd1;
                    end
                end
            end

            icce_pkg::ST_WAIT:
            begin
                if (all_done && (!out_valid_reg || out_ready))
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = icce_pkg::ST_IDLE;
                    if (emit_last)
                    begin
                        lag_next     = '0;
                        wcol_next    = '0;
                        wrow_next    = '0;
                        wr_addr_next = '0;
                        fheight_next = '0;
                        closed_next  = 1'b0;
                        ecol_next    = '0;
                        erow_next    = '0;
                        rd_addr_next = '0;
                    end
                    else
                    begin
                        rd_addr_next = (rd_addr_reg == ADDR_W'(DEPTH - 1))
                                     ? '0 : rd_addr_reg + ADDR_W'(1);
                        if (ecol_wrap)
                        begin
                            ecol_next = '0;
                            erow_next = erow_reg + 16'd1;
                        end
                        else
                        begin
                            ecol_next = ecol_reg + COL_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = icce_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= 2'd1;
            divisor_reg   <= 16'd1;
            width_reg     <= 11'd1024;
            chan_reg      <= 3'd3;
            taps_lo_reg   <= '0;
            taps_mid_reg  <= '0;
            taps_hi_reg   <= '0;
            tap_last_reg  <= '0;
            state_reg     <= icce_pkg::ST_IDLE;
            lag_reg       <= '0;
            wcol_reg      <= '0;
            wrow_reg      <= '0;
            wr_addr_reg   <= '0;
            fheight_reg   <= '0;
            closed_reg    <= 1'b0;
            ecol_reg      <= '0;
            erow_reg      <= '0;
            rd_addr_reg   <= '0;
            centre_ph_reg <= 1'b0;
            dy_reg        <= '0;
            dx_reg        <= '0;
            k_reg         <= '0;
            rv_reg        <= 1'b0;
            rc_reg        <= 1'b0;
            rf_reg        <= 1'b0;
            rl_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    icce_pkg::REG_RADIUS:   radius_reg   <= cfg_data[1:0];
                    icce_pkg::REG_DIVISOR:  divisor_reg  <= cfg_data[15:0];
                    icce_pkg::REG_WIDTH:    width_reg    <= cfg_data[10:0];
                    icce_pkg::REG_CHANNELS: chan_reg     <= cfg_data[2:0];
                    icce_pkg::REG_TAPS_LO:  taps_lo_reg  <= cfg_data;
                    icce_pkg::REG_TAPS_MID: taps_mid_reg <= cfg_data;
                    icce_pkg::REG_TAPS_HI:  taps_hi_reg  <= cfg_data;
                    icce_pkg::REG_TAP_LAST: tap_last_reg <= cfg_data[7:0];
                    default:                radius_reg   <= radius_reg;
                endcase
            end
            state_reg     <= state_next;
            lag_reg       <= lag_next;
            wcol_reg      <= wcol_next;
            wrow_reg      <= wrow_next;
            wr_addr_reg   <= wr_addr_next;
            fheight_reg   <= fheight_next;
            closed_reg    <= closed_next;
            ecol_reg      <= ecol_next;
            erow_reg      <= erow_next;
            rd_addr_reg   <= rd_addr_next;
            centre_ph_reg <= centre_ph_next;
            dy_reg        <= dy_next;
            dx_reg        <= dx_next;
            k_reg         <= k_next;
            rv_reg        <= rv_next;
            rc_reg        <= rc_next;
            rf_reg        <= rf_next;
            rl_reg        <= rl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ring store and datapath registers
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr_reg] <= {in_byte3, in_byte2, in_byte1, in_byte0};
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
        tap_reg <= tap_ext;
        if (rv_reg && rc_reg)
        begin
            centre_reg <= rdata_reg;
        end
        if (load_out)
        begin
            ob_reg[0] <= res_byte[0];
            ob_reg[1] <= res_byte[1];
            ob_reg[2] <= res_byte[2];
            ob_reg[3] <= res_byte[3];
            olast_reg <= emit_last;
        end
    end

    assign link[0] = '{valid: rv_reg && !rc_reg, first: rf_reg, last: rl_reg,
                       word: rdata_reg, tap: tap_reg};

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_cell
        icce_cell #(
            .LANE (c)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (link[c]),
            .divisor  (div_eff),
            .link_out (link[c+1]),
            .stat_out (stat[c])
        );
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_res
        if (c < CHANNELS)
        begin : g_filt
            assign res_byte[c] = (3'(c) < nch_eff) ? stat[c].result : centre_reg[c*8 +: 8];
        end
        else
        begin : g_pass
            assign res_byte[c] = centre_reg[c*8 +: 8];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte0 = ob_reg[0];
    assign out_byte1 = ob_reg[1];
    assign out_byte2 = ob_reg[2];
    assign out_byte3 = ob_reg[3];
    assign out_last  = olast_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the clamped-edge image convolution block.
`timescale 1ns / 100ps
module tb_top;

    localparam int unsigned RING_DEPTH = 1024 * 5;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned SETTLE = 80;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = icce_pkg::REG_RADIUS;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = icce_pkg::OP_PUSH;
    logic [7:0]  in_byte0 = '0;
    logic [7:0]  in_byte1 = '0;
    logic [7:0]  in_byte2 = '0;
    logic [7:0]  in_byte3 = '0;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [7:0]  out_byte3;
    logic        out_last;

    image_convolution_clamped_edges DUT (.*);

    always #2 clk = ~clk;

    // Predictor state
    logic [1:0]  m_radius;
    logic [15:0] m_divisor;
    logic [10:0] m_width;
    logic [2:0]  m_channels;
    logic [63:0] m_taps_lo, m_taps_mid, m_taps_hi;
    logic [7:0]  m_tap_last;
    logic [31:0] ring [RING_DEPTH];
    int unsigned wr_col, wr_row, em_col, em_row, height;
    bit          closed;
    int unsigned wr_ptr, rd_ptr, lag_fill;

    pixel_t      pending_pixels [$];
    int unsigned mismatches = 0;
    int unsigned words_checked = 0;
    int unsigned items_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned cycles = 0;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned ring_fill = 0;

    function automatic void queue_pixel(pixel_t p);
        pending_pixels.insert(pending_pixels.size(), p);
    endfunction

    function automatic int unsigned eff_width();
        if (m_width == 0) return 1;
        if (m_width > 1024) return 1024;
        return m_width;
    endfunction

    function automatic int eff_radius();
        return (m_radius >= 2) ? 2 : 1;
    endfunction

    function automatic int tap_of(int k);
        logic [63:0] w;
        logic [7:0]  b;
        if (k < 8) w = m_taps_lo;
        else if (k < 16) w = m_taps_mid;
        else if (k < 24) w = m_taps_hi;
        else w = {56'd0, m_tap_last};
        b = w[(k % 8) * 8 +: 8];
        return $signed(b);
    endfunction

    function automatic void clear_frame();
        wr_col = 0; wr_row = 0; em_col = 0; em_row = 0; height = 0;
        closed = 0; wr_ptr = 0; rd_ptr = 0; lag_fill = 0;
    endfunction

    function automatic pixel_t convolve_pixel();
        int unsigned w;
        int r, nch, last_row, ry, cx, off, a, k;
        longint s, q;
        logic [31:0] centre;
        logic [7:0]  res [4];
        pixel_t p;
        w = eff_width();
        r = eff_radius();
        nch = m_channels;
        if (nch == 0) nch = 1;
        if (nch > 4) nch = 4;
        last_row = (height - 1) & 16'hFFFF;
        centre = ring[rd_ptr];
        for (int c = 0; c < 4; c++) begin
            res[c] = centre[8*c +: 8];
            if (c < nch) begin
                s = 0;
                for (int dy = -r; dy <= r; dy++) begin
                    ry = int'(em_row) + dy;
                    if (ry < 0) ry = 0;
                    if (closed && ry > last_row) ry = last_row;
                    for (int dx = -r; dx <= r; dx++) begin
                        cx = int'(em_col) + dx;
                        if (cx < 0) cx = 0;
                        if (cx > int'(w) - 1) cx = int'(w) - 1;
                        k = (dy + r) * (2 * r + 1) + (dx + r);
                        off = (ry - int'(em_row)) * int'(w) + (cx - int'(em_col));
                        a = (int'(rd_ptr) + 3 * RING_DEPTH + off) % RING_DEPTH;
                        s += longint'(ring[a][8*c +: 8]) * tap_of(k);
                    end
                end
                if (s <= 0) res[c] = 8'd0;
                else begin
                    q = s / ((m_divisor == 0) ? 1 : m_divisor);
                    res[c] = (q > 255) ? 8'd255 : q[7:0];
                end
            end
        end
        p.b0 = res[0]; p.b1 = res[1]; p.b2 = res[2]; p.b3 = res[3];
        p.last = closed && int'(em_row) == last_row && em_col + 1 >= w;
        if (p.last) clear_frame();
        else begin
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            if (em_col + 1 >= w) begin
                em_col = 0;
                em_row = (em_row + 1) & 16'hFFFF;
            end else em_col++;
        end
        return p;
    endfunction

    function automatic void predict_item(logic o, logic [7:0] a0, logic [7:0] a1,
                                         logic [7:0] a2, logic [7:0] a3, logic fe);
        int unsigned w, lag;
        w = eff_width();
        if (o == icce_pkg::OP_DRAIN) begin
            if (closed) queue_pixel(convolve_pixel());
            return;
        end
        if (closed) return;
        ring[wr_ptr] = {a3, a2, a1, a0};
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        if (wr_ptr > ring_fill) ring_fill = wr_ptr;
        if (fe) begin
            height = (wr_row + 1) & 16'hFFFF;
            closed = 1;
        end
        if (wr_col + 1 >= w) begin
            wr_col = 0;
            wr_row = (wr_row + 1) & 16'hFFFF;
        end else wr_col++;
        lag = eff_radius() * w + eff_radius();
        if (lag_fill >= lag) queue_pixel(convolve_pixel());
        else lag_fill++;
    endfunction

    task automatic send_item(logic o, logic fe);
        logic [7:0] a0, a1, a2, a3;
        a0 = 8'($urandom); a1 = 8'($urandom); a2 = 8'($urandom); a3 = 8'($urandom);
        while ($urandom_range(99) < send_idle) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        op <= o;
        in_byte0 <= a0; in_byte1 <= a1; in_byte2 <= a2; in_byte3 <= a3;
        frame_end <= fe;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(o, a0, a1, a2, a3, fe);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            icce_pkg::REG_RADIUS:   m_radius = val[1:0];
            icce_pkg::REG_DIVISOR:  m_divisor = val[15:0];
            icce_pkg::REG_WIDTH:    m_width = val[10:0];
            icce_pkg::REG_CHANNELS: m_channels = val[2:0];
            icce_pkg::REG_TAPS_LO:  m_taps_lo = val;
            icce_pkg::REG_TAPS_MID: m_taps_mid = val;
            icce_pkg::REG_TAPS_HI:  m_taps_hi = val;
            default:                m_tap_last = val[7:0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [1:0] rad, logic [15:0] dv, logic [10:0] wd, logic [2:0] ch,
                         logic [63:0] lo, logic [63:0] mid, logic [63:0] hi, logic [7:0] tl);
        wait_idle();
        write_reg(icce_pkg::REG_RADIUS, 64'(rad));
        write_reg(icce_pkg::REG_DIVISOR, 64'(dv));
        write_reg(icce_pkg::REG_WIDTH, 64'(wd));
        write_reg(icce_pkg::REG_CHANNELS, 64'(ch));
        write_reg(icce_pkg::REG_TAPS_LO, lo);
        write_reg(icce_pkg::REG_TAPS_MID, mid);
        write_reg(icce_pkg::REG_TAPS_HI, hi);
        write_reg(icce_pkg::REG_TAP_LAST, 64'(tl));
    endtask

    // Push one frame of n pixels, with optional ignored words, then drain it
    task automatic run_frame(int unsigned n, bit noise);
        if (noise) send_item(icce_pkg::OP_DRAIN, 1'b0);
        for (int unsigned i = 0; i < n; i++) send_item(icce_pkg::OP_PUSH, i == n - 1);
        if (noise) send_item(icce_pkg::OP_PUSH, 1'b0);
        while (closed) send_item(icce_pkg::OP_DRAIN, 1'($urandom_range(1)));
        frames_sent++;
    endtask

    task automatic test_wide_row();
        setup(2'd2, 16'd25, 11'd32, 3'd4, {8{8'h01}}, {8{8'h01}}, {8{8'h01}}, 8'h01);
        run_frame(32, 0);
    endtask

    task automatic test_saturation();
        setup(2'd1, 16'd1, 11'd3, 3'd3, {8{8'h7F}}, {8{8'h7F}}, '0, 8'h00);
        run_frame(6, 1);
    endtask

    task automatic test_negative_taps();
        setup(2'd0, 16'd0, 11'd0, 3'd0, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, 8'h80);
        run_frame(3, 0);
    endtask

    task automatic test_radius_above();
        setup(2'd3, 16'hFFFF, 11'd2, 3'd7, 64'h0102_0304_0506_0708,
              64'hFF10_2030_4050_6070, 64'h7F01_02FE_0304_0506, 8'h7F);
        run_frame(8, 1);
    endtask

    task automatic test_random_frames(int unsigned count);
        int unsigned start, w, h, n;
        logic [15:0] dv;
        start = items_sent;
        while (items_sent - start < count) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            case ($urandom_range(3))
                0: dv = 16'($urandom_range(1));
                1: dv = 16'hFFFF;
                2: dv = 16'($urandom_range(2, 40));
                default: dv = 16'($urandom);
            endcase
            setup(2'($urandom), dv, 11'(w), 3'($urandom_range(7)),
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  8'($urandom));
            n = w * h;
            if (w * h <= ring_fill && $urandom_range(3) == 0)
                n = w * (h - 1) + $urandom_range(1, w);
            run_frame(n, 1'($urandom_range(1)));
        end
    endtask

    always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk) begin
        pixel_t got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && out_valid && out_ready) begin
            got = {out_byte0, out_byte1, out_byte2, out_byte3, out_last};
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = pending_pixels.pop_front();
                words_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected %h %h %h %h last %b, got %h %h %h %h last %b",
                                 words_checked, want.b0, want.b1, want.b2, want.b3, want.last,
                                 got.b0, got.b1, got.b2, got.b3, got.last);
                end
            end
        end
    end

    initial begin
        m_radius = 2'd1; m_divisor = 16'd1; m_width = 11'd1024; m_channels = 3'd3;
        m_taps_lo = '0; m_taps_mid = '0; m_taps_hi = '0; m_tap_last = '0;
        clear_frame();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_wide_row();
        test_saturation();
        test_negative_taps();
        test_radius_above();
        send_idle = 17; recv_idle = 66;
        test_random_frames(100);
        send_idle = 66; recv_idle = 17;
        test_random_frames(100);
        send_idle = 0; recv_idle = 0;
        test_random_frames(100);
        wait_idle();
        $display("covered %0d frames, %0d input words, %0d output words checked",
                 frames_sent, items_sent, words_checked);
        $display("radius 1 and 2, edge widths, saturation, negative taps, ignored words");
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
